/* rtl/bankers_safety_check_macros.svh */
// assertion helpers for the safety check block
`ifndef BANKERS_SAFETY_CHECK_MACROS_SVH
`define BANKERS_SAFETY_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsc assertion failed");
// antecedent implies consequent in the next cycle
`define BSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsc assertion failed");
`else
`define BSC_ASSERT_IMP(lbl, ante, cons)
`define BSC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/bsc_pkg.sv */
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int MAX_PROCESSES = 32;
  localparam int COUNT_WIDTH   = 16;
  localparam int FREE_W        = 22;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int PN_W          = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 6 * COUNT_WIDTH;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVAIL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVAIL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVAIL_C = 2'd2;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] alloc_a;
    logic [COUNT_WIDTH-1:0] alloc_b;
    logic [COUNT_WIDTH-1:0] alloc_c;
    logic [COUNT_WIDTH-1:0] claim_a;
    logic [COUNT_WIDTH-1:0] claim_b;
    logic [COUNT_WIDTH-1:0] claim_c;
    logic                   last_row;
  } in_t;

  typedef struct packed {
    logic [PN_W-1:0]   process_number;
    logic [FREE_W-1:0] free_a;
    logic [FREE_W-1:0] free_b;
    logic [FREE_W-1:0] free_c;
    logic              safe;
    logic              overflow;
    logic              last;
  } out_t;

  // clamped need: claim minus allocation, zero when negative
  function automatic logic [COUNT_WIDTH-1:0] need_of(input logic [COUNT_WIDTH-1:0] claim,
                                                     input logic [COUNT_WIDTH-1:0] alloc);
    need_of = (claim > alloc) ? (claim - alloc) : '0;
  endfunction

  // saturating add of a released allocation onto a working amount
  function automatic logic [FREE_W-1:0] sat_add(input logic [FREE_W-1:0] w,
                                                input logic [COUNT_WIDTH-1:0] a);
    logic [FREE_W:0] s;
    s = {1'b0, w} + (FREE_W+1)'(a);
    sat_add = s[FREE_W] ? {FREE_W{1'b1}} : s[FREE_W-1:0];
  endfunction

endpackage

/* rtl/bankers_safety_check.sv */
`timescale 1ns / 1ps
// banker's algorithm safety check, three resource types
// input channel (in_valid/in_ready/in_data): one word per process row, allocation
//   and maximum claim; the word with last_row set closes the table and starts the check
// config port (cfg_we/cfg_index/cfg_wdata): initial available amounts, written while idle
// result channel (out_valid/out_ready/out_data): one word per finished row in the
//   order found, then last set on the final word; an unsafe table ends with a
//   process_number 0 / safe 0 word, too many rows with a single overflow word
// throughput: rows that are not last are taken one per cycle, back to back
// the check visits rows one at a time through one compare/add unit and a
//   single-port row memory: each row visited takes a read state (S_RD), then a
//   compare state (S_CHK); an unsafe table adds a closing word; in_ready is low meanwhile
// results go through one output register; while the receiver stalls the scan
//   waits at the next finished row, and a new table may load while the final
//   word of the previous one is still held
// reset (synchronous, rst_n low): row count, overflow flag, working amounts and
//   available registers go to zero; the row memory is not cleared, only rows
//   loaded in the current table are ever read
`include "bankers_safety_check_macros.svh"
module bankers_safety_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bsc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bsc_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::COUNT_WIDTH-1:0]   cfg_wdata
);
  import bsc_pkg::*;

  // sequencer states
  localparam logic [2:0] S_LOAD = 3'd0;  // taking rows
  localparam logic [2:0] S_RD   = 3'd1;  // memory read of current row
  localparam logic [2:0] S_CHK  = 3'd2;  // compare and release
  localparam logic [2:0] S_UNS  = 3'd3;  // closing unsafe word
  localparam logic [2:0] S_OVF  = 3'd4;  // closing overflow word

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       row_cnt_r, row_cnt_nxt;
  logic                   row_ovf_r, row_ovf_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       completed_r, completed_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   progress_r, progress_nxt;
  logic [MAX_PROCESSES-1:0] done_r, done_nxt;
  logic [FREE_W-1:0]      work_a_r, work_a_nxt;
  logic [FREE_W-1:0]      work_b_r, work_b_nxt;
  logic [FREE_W-1:0]      work_c_r, work_c_nxt;
  logic [COUNT_WIDTH-1:0] avail_a_r, avail_b_r, avail_c_r;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  // row memory: alloc a/b/c then need a/b/c
  logic [ROW_W-1:0]       row_mem [MAX_PROCESSES];
  logic [ROW_W-1:0]       rd_data_r;
  logic [ROW_W-1:0]       wr_data;
  logic                   wr_en;

  logic [COUNT_WIDTH-1:0] m_alloc_a, m_alloc_b, m_alloc_c;
  logic [COUNT_WIDTH-1:0] m_need_a, m_need_b, m_need_c;
  logic                   can_emit;
  logic                   row_fit;
  logic                   pass_end;
  logic                   in_fire;
  logic [FREE_W-1:0]      sum_a, sum_b, sum_c;
  logic [CNT_W-1:0]       completed_inc;

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign can_emit  = !out_valid_r || out_ready;

  assign {m_alloc_a, m_alloc_b, m_alloc_c, m_need_a, m_need_b, m_need_c} = rd_data_r;

  // shared compare/add unit
  assign row_fit = !done_r[idx_r] &&
                   (FREE_W'(m_need_a) <= work_a_r) &&
                   (FREE_W'(m_need_b) <= work_b_r) &&
                   (FREE_W'(m_need_c) <= work_c_r);
  assign sum_a = sat_add(work_a_r, m_alloc_a);
  assign sum_b = sat_add(work_b_r, m_alloc_b);
  assign sum_c = sat_add(work_c_r, m_alloc_c);
  assign completed_inc = completed_r + CNT_W'(1);
  assign pass_end = ({1'b0, idx_r} == (n_r - CNT_W'(1)));

  assign wr_en   = in_fire && (row_cnt_r < CNT_W'(MAX_PROCESSES));
  assign wr_data = {in_data.alloc_a, in_data.alloc_b, in_data.alloc_c,
                    need_of(in_data.claim_a, in_data.alloc_a),
                    need_of(in_data.claim_b, in_data.alloc_b),
                    need_of(in_data.claim_c, in_data.alloc_c)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[row_cnt_r[IDX_W-1:0]] <= wr_data;
    end
    if (state_r == S_RD) begin
      rd_data_r <= row_mem[idx_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    row_ovf_nxt   = row_ovf_r;
    n_nxt         = n_r;
    completed_nxt = completed_r;
    idx_nxt       = idx_r;
    progress_nxt  = progress_r;
    done_nxt      = done_r;
    work_a_nxt    = work_a_r;
    work_b_nxt    = work_b_r;
    work_c_nxt    = work_c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (wr_en) begin
            row_cnt_nxt = row_cnt_r + CNT_W'(1);
          end else begin
            row_ovf_nxt = 1'b1;
          end
          if (in_data.last_row) begin
            // start of check: counts reset, work from the available registers
            n_nxt         = wr_en ? (row_cnt_r + CNT_W'(1)) : row_cnt_r;
            row_cnt_nxt   = '0;
            row_ovf_nxt   = 1'b0;
            completed_nxt = '0;
            idx_nxt       = '0;
            progress_nxt  = 1'b0;
            done_nxt      = '0;
            work_a_nxt    = FREE_W'(avail_a_r);
            work_b_nxt    = FREE_W'(avail_b_r);
            work_c_nxt    = FREE_W'(avail_c_r);
            state_nxt     = (row_ovf_r || !wr_en) ? S_OVF : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!(row_fit && !can_emit)) begin
          if (row_fit) begin
            done_nxt[idx_r] = 1'b1;
            completed_nxt   = completed_inc;
            work_a_nxt      = sum_a;
            work_b_nxt      = sum_b;
            work_c_nxt      = sum_c;
            out_valid_nxt   = 1'b1;
            out_nxt.process_number = PN_W'(idx_r) + PN_W'(1);
            out_nxt.free_a   = sum_a;
            out_nxt.free_b   = sum_b;
            out_nxt.free_c   = sum_c;
            out_nxt.safe     = 1'b1;
            out_nxt.overflow = 1'b0;
            out_nxt.last     = (completed_inc == n_r);
          end
          if (row_fit && (completed_inc == n_r)) begin
            state_nxt = S_LOAD;
          end else if (pass_end) begin
            if (progress_r || row_fit) begin
              idx_nxt      = '0;
              progress_nxt = 1'b0;
              state_nxt    = S_RD;
            end else begin
              state_nxt = S_UNS;
            end
          end else begin
            idx_nxt      = idx_r + IDX_W'(1);
            progress_nxt = progress_r || row_fit;
            state_nxt    = S_RD;
          end
        end
      end
      S_UNS, S_OVF: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_nxt.process_number = '0;
          out_nxt.free_a         = work_a_r;
          out_nxt.free_b         = work_b_r;
          out_nxt.free_c         = work_c_r;
          out_nxt.safe           = 1'b0;
          out_nxt.overflow       = (state_r == S_OVF);
          out_nxt.last           = 1'b1;
          state_nxt              = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      row_cnt_r   <= '0;
      row_ovf_r   <= 1'b0;
      n_r         <= '0;
      completed_r <= '0;
      idx_r       <= '0;
      progress_r  <= 1'b0;
      done_r      <= '0;
      work_a_r    <= '0;
      work_b_r    <= '0;
      work_c_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      row_ovf_r   <= row_ovf_nxt;
      n_r         <= n_nxt;
      completed_r <= completed_nxt;
      idx_r       <= idx_nxt;
      progress_r  <= progress_nxt;
      done_r      <= done_nxt;
      work_a_r    <= work_a_nxt;
      work_b_r    <= work_b_nxt;
      work_c_r    <= work_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // available amounts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_a_r <= '0;
      avail_b_r <= '0;
      avail_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AVAIL_A: avail_a_r <= cfg_wdata;
        REG_AVAIL_B: avail_b_r <= cfg_wdata;
        REG_AVAIL_C: avail_c_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // a finished-row word always names a row, a closing word never does
  `BSC_ASSERT_IMP(a_safe_has_number, out_valid_r, out_r.safe == (out_r.process_number != '0))
  // overflow word is the single closing word of its table
  `BSC_ASSERT_IMP(a_ovf_closes, out_valid_r && out_r.overflow, !out_r.safe && out_r.last)
  // the scan never counts more finished rows than the table holds
  `BSC_ASSERT_IMP(a_completed_bound, state_r == S_RD || state_r == S_CHK || state_r == S_UNS,
                  completed_r < n_r)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import bsc_pkg::*;

  // no-progress limit: the longest 32-row scan, plus the long
  // receiver hold-off and the longest sender gap, taken several times over
  localparam int WATCHDOG_LIMIT   = 20000;
  // quiet cycles after the last expected word before a register write or the end
  localparam int SETTLE_CYCLES    = 50;
  localparam int RANDOM_ITEMS     = 410;
  localparam int PHASE_ROWS       = 55;
  // the receiver holds off once, long enough to stall the scan and the input
  localparam int HOLD_CYCLES      = 600;
  localparam int HOLD_AFTER_WORDS = 40;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [FREE_W-1:0]      FREE_MAX = '1;

  // how a random row relates its claim to its allocation
  typedef enum int {ROW_FIT, ROW_NEG, ROW_NOISE} row_kind_t;

  // mirror of the safety check: row store, done bits, working amounts,
  // and the queue of result words still owed by the block
  class safe_seq_board;
    logic [COUNT_WIDTH-1:0] alloc_mem [MAX_PROCESSES][3];
    logic [COUNT_WIDTH-1:0] need_mem  [MAX_PROCESSES][3];
    bit                     finished  [MAX_PROCESSES];
    int                     rows_held;
    bit                     dropped_row;
    logic [COUNT_WIDTH-1:0] avail [3];
    out_t                   pending_words [$];
    int                     errors;
    int                     words_seen;

    function new();
      rows_held   = 0;
      dropped_row = 1'b0;
      errors      = 0;
      words_seen  = 0;
      for (int j = 0; j < 3; j++) avail[j] = '0;
    endfunction

    function void set_avail(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_WIDTH-1:0] v);
      case (idx)
        REG_AVAIL_A: avail[0] = v;
        REG_AVAIL_B: avail[1] = v;
        REG_AVAIL_C: avail[2] = v;
        default: ;
      endcase
    endfunction

    // released allocation onto a working amount, clipped at the top
    function logic [FREE_W-1:0] add_clip(input logic [FREE_W-1:0] w,
                                         input logic [COUNT_WIDTH-1:0] a);
      logic [FREE_W:0] s;
      s = {1'b0, w} + (FREE_W+1)'(a);
      return s[FREE_W] ? FREE_MAX : s[FREE_W-1:0];
    endfunction

    function void push_word(input logic [PN_W-1:0] pn, input logic [FREE_W-1:0] fa,
                            input logic [FREE_W-1:0] fb, input logic [FREE_W-1:0] fc,
                            input bit ok, input bit ovf, input bit fin);
      out_t e;
      e.process_number = pn;
      e.free_a         = fa;
      e.free_b         = fb;
      e.free_c         = fc;
      e.safe           = ok;
      e.overflow       = ovf;
      e.last           = fin;
      pending_words.insert(pending_words.size(), e);
    endfunction

    // store one accepted row; the closing row runs the whole check
    function void take_row(input in_t r);
      logic [COUNT_WIDTH-1:0] al [3];
      logic [COUNT_WIDTH-1:0] cl [3];
      logic [FREE_W-1:0]      wk [3];
      int                     n;
      int                     completed;
      bit                     progress;
      al[0] = r.alloc_a;
      al[1] = r.alloc_b;
      al[2] = r.alloc_c;
      cl[0] = r.claim_a;
      cl[1] = r.claim_b;
      cl[2] = r.claim_c;
      if (rows_held < MAX_PROCESSES) begin
        for (int j = 0; j < 3; j++) begin
          alloc_mem[rows_held][j] = al[j];
          need_mem[rows_held][j]  = (cl[j] > al[j]) ? cl[j] - al[j] : '0;
        end
        rows_held++;
      end else begin
        dropped_row = 1'b1;
      end
      if (!r.last_row) return;
      n         = rows_held;
      rows_held = 0;
      for (int j = 0; j < 3; j++) wk[j] = FREE_W'(avail[j]);
      if (dropped_row) begin
        dropped_row = 1'b0;
        push_word('0, wk[0], wk[1], wk[2], 1'b0, 1'b1, 1'b1);
        return;
      end
      for (int i = 0; i < MAX_PROCESSES; i++) finished[i] = 1'b0;
      completed = 0;
      while (completed < n) begin
        progress = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!finished[i] && FREE_W'(need_mem[i][0]) <= wk[0] &&
              FREE_W'(need_mem[i][1]) <= wk[1] && FREE_W'(need_mem[i][2]) <= wk[2]) begin
            finished[i] = 1'b1;
            completed++;
            progress = 1'b1;
            for (int j = 0; j < 3; j++) wk[j] = add_clip(wk[j], alloc_mem[i][j]);
            push_word(PN_W'(i + 1), wk[0], wk[1], wk[2], 1'b1, 1'b0, completed == n);
          end
        end
        if (!progress) begin
          push_word('0, wk[0], wk[1], wk[2], 1'b0, 1'b0, 1'b1);
          break;
        end
      end
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(input out_t w);
      out_t e;
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: process_number %0d", w.process_number);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      check_field("process_number", 32'(e.process_number), 32'(w.process_number));
      check_field("free_a", 32'(e.free_a), 32'(w.free_a));
      check_field("free_b", 32'(e.free_b), 32'(w.free_b));
      check_field("free_c", 32'(e.free_c), 32'(w.free_c));
      check_field("safe", 32'(e.safe), 32'(w.safe));
      check_field("overflow", 32'(e.overflow), 32'(w.overflow));
      check_field("last", 32'(e.last), 32'(w.last));
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COUNT_WIDTH-1:0] cfg_wdata;

  safe_seq_board board;
  bit            steady;       // no gaps on either side while set
  int            stall_left;
  bit            held_off;
  int            quiet_cycles;

  bankers_safety_check i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // everything that crosses a port is seen here, at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_avail(cfg_index, cfg_wdata);
      if (in_valid && in_ready) board.take_row(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
    end
  end

  // watchdog: cycles in a row with no word moving on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // receiver: random stalls, plus one long hold-off so the scan backs up
  // and in_ready stays low while the sender keeps offering rows
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    held_off   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && board.words_seen >= HOLD_AFTER_WORDS) begin
        held_off   = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic in_t row_of(input logic [15:0] a0, input logic [15:0] a1,
                                 input logic [15:0] a2, input logic [15:0] c0,
                                 input logic [15:0] c1, input logic [15:0] c2,
                                 input logic fin);
    in_t r;
    r.alloc_a  = a0;
    r.alloc_b  = a1;
    r.alloc_c  = a2;
    r.claim_a  = c0;
    r.claim_b  = c1;
    r.claim_c  = c2;
    r.last_row = fin;
    return r;
  endfunction

  // claim from allocation: small need, negative need, or anything at all
  function automatic logic [15:0] claim_for(input logic [15:0] alloc, input row_kind_t kind,
                                            input logic [15:0] need_mask);
    logic [16:0] sum;
    case (kind)
      ROW_NEG: begin
        if (alloc == 0) return 16'h0000;
        return 16'($urandom_range(0, alloc - 1));
      end
      ROW_FIT: begin
        sum = 17'(alloc) + 17'(16'($urandom) & need_mask);
        return sum[16] ? CNT_MAX : sum[15:0];
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t make_row(input bit fin, input bit noisy, input logic [15:0] need_mask);
    logic [15:0] al [3];
    logic [15:0] cl [3];
    row_kind_t   kind;
    int          p;
    p    = $urandom_range(0, 99);
    kind = noisy ? ROW_NOISE : ((p < 15) ? ROW_NEG : ((p < 92) ? ROW_FIT : ROW_NOISE));
    for (int j = 0; j < 3; j++) begin
      al[j] = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
      cl[j] = claim_for(al[j], kind, need_mask);
    end
    return row_of(al[0], al[1], al[2], cl[0], cl[1], cl[2], fin);
  endfunction

  // offer one row word and hold it until it is taken
  task automatic send_row(input in_t row);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain: every owed word back, then a quiet stretch
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_avail(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AVAIL_A;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_index <= REG_AVAIL_B;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_index <= REG_AVAIL_C;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  int          random_rows;
  int          phase_rows;
  int          phase;
  int          table_no;
  int          n;
  int          r;
  bit          noisy;
  logic [15:0] mask;

  initial begin
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_AVAIL_A;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: nothing available
    write_avail(16'h0000, 16'h0000, 16'h0000);
    // all-zero row finishes at once
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // full allocation, claim equal: need zero, frees everything
    send_row(row_of(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1));
    // one unit short on B: unsafe right away
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b1));
    // claim below allocation clamps the need to zero
    send_row(row_of(16'h0005, 16'h0007, 16'h0009, 16'h0002, 16'h0000, 16'h0009, 1'b1));
    // first row only fits on the second pass
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h000a, 16'h0000, 16'h0000, 1'b0));
    send_row(row_of(16'h000a, 16'h0000, 16'h0000, 16'h000a, 16'h0000, 16'h0000, 1'b0));
    send_row(row_of(16'h0003, 16'h0003, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // one row done, then stuck
    send_row(row_of(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0));
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'h0000, 16'h0000, 1'b1));
    settle();

    // directed: everything available
    write_avail(CNT_MAX, CNT_MAX, CNT_MAX);
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1));
    send_row(row_of(16'haaaa, 16'h5555, CNT_MAX, 16'h5555, 16'haaaa, 16'h0000, 1'b0));
    send_row(row_of(16'h5555, 16'haaaa, 16'h0000, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1));
    settle();

    // directed: mixed amounts, progress over two passes and then stuck
    write_avail(16'h0000, CNT_MAX, 16'h0001);
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0));
    send_row(row_of(16'h0002, 16'h0000, 16'h0000, 16'h0000, CNT_MAX, 16'h0001, 1'b0));
    send_row(row_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 1'b1));

    // random tables, phase by phase with fresh available amounts
    random_rows = 0;
    phase       = 0;
    table_no    = 0;
    while (random_rows < RANDOM_ITEMS) begin
      settle();
      case (phase % 5)
        0: write_avail(CNT_MAX, CNT_MAX, CNT_MAX);
        1: write_avail(16'h0000, 16'h0000, 16'h0000);
        2: write_avail(16'($urandom), 16'($urandom), 16'($urandom));
        3: write_avail(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)));
        default: write_avail(16'($urandom_range(0, 4095)), CNT_MAX,
                             16'($urandom_range(0, 15)));
      endcase
      steady     = (phase % 4 == 2);
      phase_rows = 0;
      while (phase_rows < PHASE_ROWS && random_rows < RANDOM_ITEMS) begin
        // a full store, and overflow by two and by one, come early for sure
        if (table_no == 2) n = MAX_PROCESSES;
        else if (table_no == 5) n = MAX_PROCESSES + 2;
        else if (table_no == 9) n = MAX_PROCESSES + 1;
        else begin
          r = $urandom_range(0, 99);
          if (r < 70) n = $urandom_range(1, 5);
          else if (r < 90) n = $urandom_range(6, 12);
          else if (r < 97) n = $urandom_range(13, MAX_PROCESSES);
          else n = $urandom_range(MAX_PROCESSES + 1, MAX_PROCESSES + 4);
        end
        noisy = ($urandom_range(0, 99) < 20) && (n != MAX_PROCESSES);
        case ($urandom_range(0, 3))
          0: mask = 16'h0000;
          1: mask = 16'h000f;
          2: mask = 16'h00ff;
          default: mask = 16'h0fff;
        endcase
        for (int i = 0; i < n; i++) send_row(make_row(i == n - 1, noisy, mask));
        phase_rows  += n;
        random_rows += n;
        table_no++;
      end
      phase++;
    end

    steady = 1'b0;
    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
